/* rtl/hvt_pkg.sv */
// ----------------------------------------------------------------------------
// hvt_pkg
// Shared types and constants for the homogeneous vertex transform.
// ----------------------------------------------------------------------------
package hvt_pkg;

  // default fraction bits of the fixed point format
  localparam int FRAC_BITS_DEF = 16;

  // configuration register file
  localparam int NUM_REGS  = 8;
  localparam int CFG_IDX_W = 8;

  // register indexes
  localparam logic [2:0] REG_R0_C0C1 = 3'd0;
  localparam logic [2:0] REG_R0_C2C3 = 3'd1;
  localparam logic [2:0] REG_R1_C0C1 = 3'd2;
  localparam logic [2:0] REG_R1_C2C3 = 3'd3;
  localparam logic [2:0] REG_R2_C0C1 = 3'd4;
  localparam logic [2:0] REG_R2_C2C3 = 3'd5;
  localparam logic [2:0] REG_R3_C0C1 = 3'd6;
  localparam logic [2:0] REG_R3_C2C3 = 3'd7;

  // queue between front and back
  localparam int QUEUE_DEPTH = 8;
  localparam int QPW         = $clog2(QUEUE_DEPTH);
  localparam int QCW         = $clog2(QUEUE_DEPTH + 1);

  // quotient bits resolved by the divider
  localparam int DIV_BITS = 32;

  // classified item handed from front to back
  typedef struct packed {
    logic              wz;       // w is zero
    logic [2:0][31:0]  zval;     // saturated undivided values
    logic              zclamp;   // any undivided value clamped
    logic [2:0][63:0]  num;      // dividend magnitudes (remainder in divider)
    logic [2:0]        neg;      // quotient sign
    logic [2:0]        big;      // quotient at least 2^32
    logic [63:0]       wm;       // divisor magnitude
  } hvt_item_t;

endpackage

/* rtl/hvt_front.sv */
// ----------------------------------------------------------------------------
// hvt_front
// Coefficient registers, matrix multiply, and classification of w.
// ----------------------------------------------------------------------------
module hvt_front
  import hvt_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]          cfg_data,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [95:0]          in_tdata,
  input  logic [QCW-1:0]       q_count,
  output logic                 q_push,
  output hvt_item_t            q_item
);

  localparam int AW = 66 - FRAC_BITS;
  localparam logic [63:0] ONE_HI = 64'd1 << (32 + FRAC_BITS);
  localparam logic [63:0] ONE_LO = 64'd1 << FRAC_BITS;

  logic [63:0] coef_r [NUM_REGS];
  logic signed [31:0] cf [4][4];
  logic signed [31:0] pos [3];

  logic v1_r, v2_r, v3_r;
  logic signed [63:0] prod_r [3][4];
  logic signed [63:0] prod_nxt [3][4];
  logic signed [AW-1:0] a_r [4];
  logic signed [AW-1:0] a_nxt [4];
  hvt_item_t item_r, item_nxt;
  logic [QCW:0] occ;

  // configuration writes, unknown indexes ignored
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r[REG_R0_C0C1] <= ONE_HI;
      coef_r[REG_R0_C2C3] <= '0;
      coef_r[REG_R1_C0C1] <= ONE_LO;
      coef_r[REG_R1_C2C3] <= '0;
      coef_r[REG_R2_C0C1] <= '0;
      coef_r[REG_R2_C2C3] <= ONE_HI;
      coef_r[REG_R3_C0C1] <= '0;
      coef_r[REG_R3_C2C3] <= ONE_LO;
    end else if (cfg_valid && cfg_index < CFG_IDX_W'(NUM_REGS)) begin
      coef_r[cfg_index[2:0]] <= cfg_data;
    end
  end

  // coefficient matrix view
  always_comb begin
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        cf[r][c] = (c % 2 == 1) ? coef_r[3'(r * 2 + c / 2)][31:0]
                                : coef_r[3'(r * 2 + c / 2)][63:32];
      end
    end
  end

  // credit against queue space
  assign occ = (QCW + 1)'(q_count) + (QCW + 1)'(v1_r) + (QCW + 1)'(v2_r)
             + (QCW + 1)'(v3_r);
  assign in_tready = occ < (QCW + 1)'(QUEUE_DEPTH);

  // stage 1: products
  always_comb begin
    pos[0] = in_tdata[31:0];
    pos[1] = in_tdata[63:32];
    pos[2] = in_tdata[95:64];
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 4; j++) begin
        prod_nxt[i][j] = pos[i] * cf[i][j];
      end
    end
  end

  // stage 2: floored sum plus constant row
  always_comb begin
    logic signed [64:0] sum;
    for (int j = 0; j < 4; j++) begin
      sum = 65'(prod_r[0][j]) + 65'(prod_r[1][j]) + 65'(prod_r[2][j]);
      a_nxt[j] = AW'(sum >>> FRAC_BITS) + AW'(cf[3][j]);
    end
  end

  // stage 3: classify w, dividend and divisor magnitudes
  always_comb begin
    logic [AW-1:0] m;
    logic [AW-1:0] mw;
    logic          ovf;
    mw = a_r[3][AW-1] ? (~$unsigned(a_r[3]) + 1'b1) : $unsigned(a_r[3]);
    item_nxt.wm = 64'(mw);
    item_nxt.wz = (a_r[3] == '0);
    item_nxt.zclamp = 1'b0;
    for (int j = 0; j < 3; j++) begin
      m = a_r[j][AW-1] ? (~$unsigned(a_r[j]) + 1'b1) : $unsigned(a_r[j]);
      item_nxt.num[j] = 64'(m) << FRAC_BITS;
      item_nxt.neg[j] = a_r[j][AW-1] ^ a_r[3][AW-1];
      item_nxt.big[j] = {32'd0, item_nxt.num[j]} >= {item_nxt.wm, 32'd0};
      ovf = !((&a_r[j][AW-1:31]) || (a_r[j][AW-1:31] == '0));
      if (ovf) begin
        item_nxt.zval[j] = a_r[j][AW-1] ? 32'h8000_0000 : 32'h7fff_ffff;
      end else begin
        item_nxt.zval[j] = a_r[j][31:0];
      end
      item_nxt.zclamp = item_nxt.zclamp | ovf;
    end
  end

  // pipeline valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= in_tvalid && in_tready;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    a_r    <= a_nxt;
    item_r <= item_nxt;
  end

  assign q_push = v3_r;
  assign q_item = item_r;

endmodule

/* rtl/hvt_queue.sv */
// ----------------------------------------------------------------------------
// hvt_queue
// Small FIFO between the classifying front and the dividing back.
// ----------------------------------------------------------------------------
module hvt_queue
  import hvt_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  hvt_item_t      push_item,
  input  logic           pop,
  output logic           pop_valid,
  output hvt_item_t      pop_item,
  output logic [QCW-1:0] count
);

  hvt_item_t mem_r [QUEUE_DEPTH];
  logic [QPW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCW-1:0] count_r;

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r <= count_r + QCW'(push) - QCW'(pop);
    end
  end

  assign pop_valid = (count_r != '0);
  assign pop_item  = mem_r[rd_ptr_r];
  assign count     = count_r;

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (count_r < QCW'(QUEUE_DEPTH)))
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (count_r != '0))
    else $error("queue pop while empty");
`endif

endmodule

/* rtl/hvt_back.sv */
// ----------------------------------------------------------------------------
// hvt_back
// Pipelined restoring divider, one quotient bit per stage, then saturation.
// ----------------------------------------------------------------------------
module hvt_back
  import hvt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  input  hvt_item_t   q_item,
  output logic        q_pop,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [95:0] out_tdata,
  output logic [1:0]  out_tuser
);

  logic en;
  logic      v_r   [DIV_BITS+1];
  hvt_item_t it_r  [DIV_BITS+1];
  logic [2:0][DIV_BITS-1:0] quo_r [DIV_BITS+1];

  logic        out_tvalid_r;
  logic [95:0] out_tdata_r, out_tdata_nxt;
  logic [1:0]  out_tuser_r, out_tuser_nxt;

  // whole pipe advances when the output register is free
  assign en    = !out_tvalid_r || out_tready;
  assign q_pop = en && q_valid;

  // stage 0: load from queue
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= q_valid;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      it_r[0]  <= q_item;
      quo_r[0] <= '0;
    end
  end

  // divider stages, most significant quotient bit first
  for (genvar s = 1; s <= DIV_BITS; s++) begin : g_div
    localparam int B = DIV_BITS - s;
    hvt_item_t it_nxt;
    logic [2:0][DIV_BITS-1:0] quo_nxt;

    always_comb begin
      logic [95:0] dsh;
      logic        ge;
      it_nxt  = it_r[s-1];
      quo_nxt = quo_r[s-1];
      dsh = {32'd0, it_r[s-1].wm} << B;
      for (int j = 0; j < 3; j++) begin
        ge = {32'd0, it_r[s-1].num[j]} >= dsh;
        if (ge) it_nxt.num[j] = it_r[s-1].num[j] - dsh[63:0];
        quo_nxt[j][B] = ge;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else if (en) begin
        v_r[s] <= v_r[s-1];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        it_r[s]  <= it_nxt;
        quo_r[s] <= quo_nxt;
      end
    end
  end

  // sign and saturation of the quotients
  always_comb begin
    logic [DIV_BITS-1:0] q;
    logic [31:0]         val;
    logic                cl;
    logic                any_cl;
    any_cl = 1'b0;
    for (int j = 0; j < 3; j++) begin
      q  = quo_r[DIV_BITS][j];
      cl = 1'b0;
      if (it_r[DIV_BITS].wz) begin
        val = it_r[DIV_BITS].zval[j];
      end else if (it_r[DIV_BITS].big[j]) begin
        cl  = 1'b1;
        val = it_r[DIV_BITS].neg[j] ? 32'h8000_0000 : 32'h7fff_ffff;
      end else if (it_r[DIV_BITS].neg[j] && q != '0) begin
        if (q > 32'h8000_0000) begin
          cl  = 1'b1;
          val = 32'h8000_0000;
        end else begin
          val = ~q + 1'b1;
        end
      end else if (q[31]) begin
        cl  = 1'b1;
        val = 32'h7fff_ffff;
      end else begin
        val = q;
      end
      out_tdata_nxt[j*32 +: 32] = val;
      any_cl = any_cl | cl;
    end
    out_tuser_nxt[0] = it_r[DIV_BITS].wz;
    out_tuser_nxt[1] = it_r[DIV_BITS].wz ? it_r[DIV_BITS].zclamp : any_cl;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (en) begin
      out_tvalid_r <= v_r[DIV_BITS];
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      out_tdata_r <= out_tdata_nxt;
      out_tuser_r <= out_tuser_nxt;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

`ifndef ASSERT_OFF
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[DIV_BITS] && !en) |=> v_r[DIV_BITS])
    else $error("divider item lost during stall");
`endif

endmodule

/* rtl/homogeneous_vertex_transform.sv */
// Path from an accepted transaction to out_tvalid: three multiply/sum/classify stages,
// the queue, the load stage, 32 divider stages and the output register.
// Throughput: one point per cycle unless the output stalls; one quotient bit per stage.
// Reset: rst_n synchronous active low; empties the pipes and queue and loads
// the identity matrix into the coefficient registers.
// ----------------------------------------------------------------------------
// homogeneous_vertex_transform
// 4x4 matrix transform of (x, y, z, 1), perspective divide by w unless w is zero.
// ----------------------------------------------------------------------------
module homogeneous_vertex_transform
  import hvt_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]          cfg_data,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [95:0]          in_tdata,   // pos_x, pos_y, pos_z
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [95:0]          out_tdata,  // out_x, out_y, out_z
  output logic [1:0]           out_tuser   // w_was_zero, saturated
);

  logic           q_push, q_pop, q_valid;
  hvt_item_t      q_in, q_out;
  logic [QCW-1:0] q_count;

  // front: multiply and classify
  hvt_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .q_count(q_count), .q_push(q_push), .q_item(q_in)
  );

  // decoupling queue
  hvt_queue u_queue (
    .clk(clk), .rst_n(rst_n),
    .push(q_push), .push_item(q_in),
    .pop(q_pop), .pop_valid(q_valid), .pop_item(q_out),
    .count(q_count)
  );

  // back: divide and saturate
  hvt_back u_back (
    .clk(clk), .rst_n(rst_n),
    .q_valid(q_valid), .q_item(q_out), .q_pop(q_pop),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

endmodule

/* test/tb_homogeneous_vertex_transform.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_homogeneous_vertex_transform
// Streams points through the 4x4 transform under several coefficient sets,
// predicts each transformed point with an exact behavioral model and checks
// every output transaction in order, with random stalls on both sides.
// ----------------------------------------------------------------------------
module tb_homogeneous_vertex_transform;
  import hvt_pkg::*;

  localparam int FB        = FRAC_BITS_DEF;
  localparam int IDLE_MAX  = 14;
  localparam int WD_LIMIT  = 20000;
  localparam int DRAIN_CYC = 60;

  typedef struct packed {
    logic [31:0] z;
    logic [31:0] y;
    logic [31:0] x;
  } point_t;

  typedef struct {
    logic [95:0] data;
    logic [1:0]  flags;
  } xform_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [63:0]  cfg_data = '0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [95:0]  in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [95:0]  out_tdata;
  logic [1:0]   out_tuser;

  homogeneous_vertex_transform dut (.*);

  // clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  logic [63:0]  coef_file [NUM_REGS];
  point_t       point_q [$];
  xform_t       xform_q [$];
  int           errors = 0;
  int           in_wait = 0;
  int           out_wait = 0;
  int           idle_cycles = 0;
  bit           hold_input = 1'b0;
  bit           in_busy = 1'b0;

  function automatic logic signed [31:0] coef_of(int row, int col);
    logic [63:0] r;
    r = coef_file[row * 2 + col / 2];
    return (col % 2) ? r[31:0] : r[63:32];
  endfunction

  // clamp a wide value to 32 bits
  function automatic logic [31:0] clamp32(logic signed [127:0] v, ref bit hit);
    if (v > 128'sd2147483647) begin
      hit = 1'b1;
      return 32'h7fffffff;
    end
    if (v < -128'sd2147483648) begin
      hit = 1'b1;
      return 32'h80000000;
    end
    return v[31:0];
  endfunction

  function automatic xform_t transform_point(point_t p);
    logic signed [127:0] acc [4];
    logic signed [127:0] sum, num, den, q;
    logic signed [31:0]  pc [3];
    logic [31:0]         res [3];
    bit                  hit;
    xform_t              r;
    hit = 1'b0;
    pc[0] = p.x;
    pc[1] = p.y;
    pc[2] = p.z;
    for (int j = 0; j < 4; j++) begin
      sum = 0;
      for (int i = 0; i < 3; i++)
        sum += 128'(pc[i]) * 128'(coef_of(i, j));
      // floor of the exact sum, then the constant row
      acc[j] = (sum >>> FB) + 128'(coef_of(3, j));
    end
    for (int j = 0; j < 3; j++) begin
      if (acc[3] == 0) begin
        res[j] = clamp32(acc[j], hit);
      end else begin
        num = acc[j] <<< FB;
        den = acc[3];
        // signed division truncates toward zero
        q = num / den;
        res[j] = clamp32(q, hit);
      end
    end
    r.data  = {res[2], res[1], res[0]};
    r.flags = {hit, acc[3] == 0};
    return r;
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 16'hffff)) - 32'sd32768) <<< 8;
      2: return {$urandom_range(0, 1) ? 16'hffff : 16'h0, 16'($urandom())};
      default: return 32'($signed($urandom_range(0, 32'h00ffffff)) - 32'sh00800000);
    endcase
  endfunction

  // driver
  always @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      xform_q.push_back(transform_point(in_tdata));
    end
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_busy   <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (hold_input) begin
        in_tvalid <= 1'b0;
        in_busy   <= 1'b0;
      end else if (in_wait > 0) begin
        in_wait   <= in_wait - 1;
        in_tvalid <= 1'b0;
        in_busy   <= 1'b0;
      end else if (point_q.size() > 0) begin
        in_tdata  <= point_q.pop_front();
        in_tvalid <= 1'b1;
        in_busy   <= 1'b1;
        in_wait   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, IDLE_MAX);
      end else begin
        in_tvalid <= 1'b0;
        in_busy   <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    xform_t want;
    if (out_tvalid && out_tready) begin
      if (xform_q.size() == 0) begin
        errors++;
        $display("%0t unexpected result: expected none, actual %h %b", $time,
                 out_tdata, out_tuser);
      end else begin
        want = xform_q.pop_front();
        for (int f = 0; f < 3; f++)
          if (out_tdata[f*32 +: 32] !== want.data[f*32 +: 32]) begin
            errors++;
            $display("%0t coord %0d mismatch: expected %h, actual %h", $time, f,
                     want.data[f*32 +: 32], out_tdata[f*32 +: 32]);
          end
        if (out_tuser[0] !== want.flags[0]) begin
          errors++;
          $display("%0t w_was_zero mismatch: expected %b, actual %b", $time,
                   want.flags[0], out_tuser[0]);
        end
        if (out_tuser[1] !== want.flags[1]) begin
          errors++;
          $display("%0t saturated mismatch: expected %b, actual %b", $time,
                   want.flags[1], out_tuser[1]);
        end
      end
    end
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (out_wait > 0) begin
      out_wait <= out_wait - 1;
      out_tready <= 1'b0;
    end else if (!out_tready || out_tvalid) begin
      out_tready <= 1'b1;
      if (out_tvalid)
        out_wait <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, IDLE_MAX);
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WD_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // one register write; the caller drops cfg_valid after the last one
  task automatic write_coef(logic [2:0] idx, logic [63:0] val);
    cfg_index <= CFG_IDX_W'(idx);
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    coef_file[idx] = val;
  endtask

  task automatic drain();
    while (point_q.size() > 0 || in_busy || xform_q.size() > 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  function automatic logic [63:0] pack_coef(logic [31:0] even, logic [31:0] odd);
    return {even, odd};
  endfunction

  function automatic logic [31:0] rand_coef();
    case ($urandom_range(0, 4))
      0: return $urandom();
      1: return 32'h0;
      default: return 32'($signed($urandom_range(0, 32'h0003ffff)) - 32'sh00020000);
    endcase
  endfunction

  task automatic load_matrix(int kind);
    logic [31:0] m [4][4];
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < 4; c++)
        case (kind)
          0: m[r][c] = (r == c) ? 32'h10000 : 32'h0;
          1: m[r][c] = (c == 3) ? 32'h0 : rand_coef();           // w always zero
          2: m[r][c] = (r + c) % 2 ? 32'h80000000 : 32'h7fffffff; // extremes
          default: m[r][c] = rand_coef();
        endcase
    if (kind >= 3)
      m[3][3] = ($urandom_range(0, 1)) ? 32'h10000 : rand_coef();
    write_coef(REG_R0_C0C1, pack_coef(m[0][0], m[0][1]));
    write_coef(REG_R0_C2C3, pack_coef(m[0][2], m[0][3]));
    write_coef(REG_R1_C0C1, pack_coef(m[1][0], m[1][1]));
    write_coef(REG_R1_C2C3, pack_coef(m[1][2], m[1][3]));
    write_coef(REG_R2_C0C1, pack_coef(m[2][0], m[2][1]));
    write_coef(REG_R2_C2C3, pack_coef(m[2][2], m[2][3]));
    write_coef(REG_R3_C0C1, pack_coef(m[3][0], m[3][1]));
    write_coef(REG_R3_C2C3, pack_coef(m[3][2], m[3][3]));
    cfg_valid <= 1'b0;
  endtask

  task automatic queue_random(int n);
    point_t p;
    for (int k = 0; k < n; k++) begin
      p.x = rand_coord();
      p.y = rand_coord();
      p.z = rand_coord();
      point_q.push_back(p);
    end
  endtask

  // stimulus
  initial begin
    point_t p;
    logic [31:0] ext [6];
    ext = '{32'h0, 32'h7fffffff, 32'h80000000, 32'h10000, 32'hffff0000, 32'h1};
    // identity after reset
    coef_file[0] = 64'h0001_0000_0000_0000;
    coef_file[1] = 64'h0;
    coef_file[2] = 64'h0000_0000_0001_0000;
    coef_file[3] = 64'h0;
    coef_file[4] = 64'h0;
    coef_file[5] = 64'h0001_0000_0000_0000;
    coef_file[6] = 64'h0;
    coef_file[7] = 64'h0000_0000_0001_0000;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: field extremes through the reset identity
    for (int k = 0; k < 6; k++) begin
      p.x = ext[k];
      p.y = ext[(k + 1) % 6];
      p.z = ext[(k + 2) % 6];
      point_q.push_back(p);
    end
    drain();

    // directed: extreme coefficients force saturation
    load_matrix(2);
    for (int k = 0; k < 6; k++) begin
      p.x = ext[k];
      p.y = ext[5 - k];
      p.z = ext[(k + 3) % 6];
      point_q.push_back(p);
    end
    drain();

    // directed: w identically zero, undivided outputs
    load_matrix(1);
    for (int k = 0; k < 6; k++) begin
      p.x = ext[k];
      p.y = ext[k];
      p.z = ext[(k + 4) % 6];
      point_q.push_back(p);
    end
    queue_random(4);
    drain();

    // random phases over several matrices
    for (int ph = 0; ph < 8; ph++) begin
      load_matrix(ph == 0 ? 0 : (ph == 5 ? 1 : 3));
      queue_random(80);
      // pause the sender until everything outstanding has come back
      while (point_q.size() > 40 || in_busy) @(posedge clk);
      hold_input <= 1'b1;
      while (xform_q.size() > 0 || in_busy) @(posedge clk);
      hold_input <= 1'b0;
      queue_random(80);
      drain();
    end

    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
